// ===== rtl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// RTD converter package
// Shared widths, register indexes, reset values and curve coefficients for
// the PT100 resistance-to-temperature converter.
// ----------------------------------------------------------------------------
package rtd_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 19;

   localparam logic [CSR_INDEX_W-1:0] REG_REF_RESISTANCE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_TEMPERATURE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_STEP        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ITERATION_COUNT   = 2'd3;

   // Field widths
   localparam int RTD_WORD_W = 16;
   localparam int CODE_W     = 15;
   localparam int REF_W      = 16;
   localparam int TEMP_W     = 19;
   localparam int STEP_W     = 18;
   localparam int ITER_W     = 6;
   localparam int RES_W      = 20;

   // Register reset values
   localparam logic [REF_W-1:0]         REF_RESISTANCE_RST    = 16'd6880;
   localparam logic signed [TEMP_W-1:0] START_TEMPERATURE_RST = 19'sd83200;
   localparam logic [STEP_W-1:0]        START_STEP_RST        = 18'd67200;
   localparam logic [ITER_W-1:0]        ITERATION_COUNT_RST   = 6'd20;

   localparam int MAX_ITERATIONS_DEFAULT = 32;

   // Callendar-Van Dusen curve, resistance in units of 2^-40 ohm
   localparam logic [46:0] R0_SCALED = 47'd109951162777600;  // 100 * 2^40
   localparam logic [30:0] KA_COEF   = 31'd1678602068;
   localparam logic [25:0] KB_COEF   = 26'd63496797;
   localparam logic [33:0] KC_COEF   = 34'd7716291493;
   localparam logic [17:0] KC_HI     = KC_COEF[33:16];
   localparam logic [15:0] KC_LO     = KC_COEF[15:0];

   // Cubic term offset: 100 C in 1/256 C
   localparam logic [19:0] T_OFFSET_100C = 20'd25600;

   // Shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 26;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Curve accumulator
   localparam int ACC_W = 56;

endpackage

// ===== rtl/rtd_resistance_to_temperature.sv =====
// ----------------------------------------------------------------------------
// PT100 resistance-to-temperature converter
// Scales an RTD converter word to resistance and inverts the Callendar-Van
// Dusen curve by bisection on one shared multiplier.
// ----------------------------------------------------------------------------
// An accepted transaction drops the fault bit of rtd_word, multiplies the
// 15-bit code by the reference resistance to get the resistance (1/256 ohm)
// and then runs min(iteration_count, MAX_ITERATIONS) bisection rounds from
// start_temperature with start_step, halving the step each round. Every
// multiplication goes through a single registered 32x26 multiplier under a
// phase counter: a round runs every phase up to PH_KCH and then PH_CMP while
// the trial temperature is at or above 0 C, and all phases through PH_CMP
// below 0 C, where the cubic term is evaluated. req_stall stays high from
// acceptance until the block is idle again, also while ST_DONE waits for a
// free output register. The result sits in an output register, so the next
// transaction is taken while it waits. Configuration writes are always ready
// and must only happen while idle.
// ----------------------------------------------------------------------------
module rtd_resistance_to_temperature #(
   parameter int MAX_ITERATIONS = rtd_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_channel_select,
   input  logic [rtd_pkg::RTD_WORD_W-1:0]      req_rtd_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_channel_tag,
   output logic [rtd_pkg::RES_W-1:0]           rsp_resistance,
   output logic signed [rtd_pkg::TEMP_W-1:0]   rsp_temperature,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rtd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_TARGET = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // Round phases: each issues a product, consumes the previous one, or both; PH_CMP compares
   localparam logic [3:0] PH_UU   = 4'd0;
   localparam logic [3:0] PH_WW   = 4'd1;
   localparam logic [3:0] PH_KA   = 4'd2;
   localparam logic [3:0] PH_KBH  = 4'd3;
   localparam logic [3:0] PH_KBL  = 4'd4;
   localparam logic [3:0] PH_KCH  = 4'd5;
   localparam logic [3:0] PH_KCL  = 4'd6;
   localparam logic [3:0] PH_PSUM = 4'd7;
   localparam logic [3:0] PH_PH   = 4'd8;
   localparam logic [3:0] PH_PL   = 4'd9;
   localparam logic [3:0] PH_PEND = 4'd10;
   localparam logic [3:0] PH_CMP  = 4'd11;

   localparam logic signed [20:0] T_LO = -21'sd262144;
   localparam logic signed [20:0] T_HI = 21'sd262143;

   // Configuration registers
   logic [rtd_pkg::REF_W-1:0]         ref_resistance_ff;
   logic signed [rtd_pkg::TEMP_W-1:0] start_temperature_ff;
   logic [rtd_pkg::STEP_W-1:0]        start_step_ff;
   logic [rtd_pkg::ITER_W-1:0]        iteration_count_ff;

   // Control
   logic [2:0]       state_ff, state_in;
   logic [3:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] rounds_ff, rounds_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic                              chan_ff, chan_in;
   logic [rtd_pkg::CODE_W-1:0]        code_ff, code_in;
   logic [30:0]                       target_ff, target_in;
   logic signed [rtd_pkg::TEMP_W-1:0] t_ff, t_in;
   logic [rtd_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [36:0]                       u_ff, u_in;
   logic [36:0]                       w_ff, w_in;
   logic [rtd_pkg::PROD_W-1:0]        tmp_ff, tmp_in;
   logic signed [rtd_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [rtd_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                              rsp_tag_ff, rsp_tag_in;
   logic [rtd_pkg::RES_W-1:0]         rsp_res_ff, rsp_res_in;
   logic signed [rtd_pkg::TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;

   logic [rtd_pkg::MUL_A_W-1:0]      mul_a;
   logic [rtd_pkg::MUL_B_W-1:0]      mul_b;
   logic [rtd_pkg::TEMP_W-1:0]       t_mag;
   logic                             t_neg;
   logic [rtd_pkg::ACC_W-1:0]        acc_term;
   logic                             acc_sub;
   logic                             acc_load;
   logic signed [rtd_pkg::ACC_W-1:0] target_scaled;
   logic signed [20:0]               t_sum;
   logic                             out_free;

   assign t_neg         = t_ff[rtd_pkg::TEMP_W-1];
   assign t_mag         = t_neg ? (~t_ff + 1'b1) : t_ff;
   assign target_scaled = signed'({4'd0, target_ff, 21'd0});
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign prod_in       = rtd_pkg::PROD_W'(mul_a) * rtd_pkg::PROD_W'(mul_b);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rounds_in    = rounds_ff;
      chan_in      = chan_ff;
      code_in      = code_ff;
      target_in    = target_ff;
      t_in         = t_ff;
      step_in      = step_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      tmp_in       = tmp_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      acc_term     = '0;
      acc_sub      = 1'b0;
      acc_load     = 1'b0;
      t_sum        = {{2{t_ff[rtd_pkg::TEMP_W-1]}}, t_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               chan_in  = req_channel_select;
               code_in  = req_rtd_word[rtd_pkg::RTD_WORD_W-1:1];
               t_in     = start_temperature_ff;
               step_in  = start_step_ff;
               if ({26'd0, iteration_count_ff} > 32'(MAX_ITERATIONS)) begin
                  rounds_in = CNT_W'(MAX_ITERATIONS);
               end else begin
                  rounds_in = CNT_W'(iteration_count_ff);
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_a    = rtd_pkg::MUL_A_W'(code_ff);
            mul_b    = rtd_pkg::MUL_B_W'(ref_resistance_ff);
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            target_in = prod_ff[30:0];
            phase_in  = PH_UU;
            state_in  = (rounds_ff == '0) ? ST_DONE : ST_ROUND;
         end
         ST_ROUND: begin
            phase_in = phase_ff + 4'd1;
            unique case (phase_ff)
               PH_UU: begin
                  acc_load = 1'b1;
                  mul_a    = rtd_pkg::MUL_A_W'(t_mag);
                  mul_b    = rtd_pkg::MUL_B_W'(t_mag);
               end
               PH_WW: begin
                  u_in  = prod_ff[36:0];
                  mul_a = rtd_pkg::MUL_A_W'(t_mag) + rtd_pkg::MUL_A_W'(rtd_pkg::T_OFFSET_100C);
                  mul_b = rtd_pkg::MUL_B_W'(t_mag);
               end
               PH_KA: begin
                  w_in  = prod_ff[36:0];
                  mul_a = rtd_pkg::MUL_A_W'(rtd_pkg::KA_COEF);
                  mul_b = rtd_pkg::MUL_B_W'(t_mag);
               end
               PH_KBH: begin
                  // linear term carries the sign of t
                  acc_term = rtd_pkg::ACC_W'(prod_ff[49:0]);
                  acc_sub  = t_neg;
                  mul_a    = rtd_pkg::MUL_A_W'(u_ff[36:18]);
                  mul_b    = rtd_pkg::KB_COEF;
               end
               PH_KBL: begin
                  acc_term = rtd_pkg::ACC_W'({prod_ff[44:0], 2'b00});
                  acc_sub  = 1'b1;
                  mul_a    = rtd_pkg::MUL_A_W'(u_ff[17:0]);
                  mul_b    = rtd_pkg::KB_COEF;
               end
               PH_KCH: begin
                  acc_term = rtd_pkg::ACC_W'(prod_ff[43:16]);
                  acc_sub  = 1'b1;
                  mul_a    = rtd_pkg::MUL_A_W'(w_ff[36:12]);
                  mul_b    = rtd_pkg::MUL_B_W'(rtd_pkg::KC_HI);
                  // skip the cubic term at or above 0 C
                  if (!t_neg) begin
                     phase_in = PH_CMP;
                  end
               end
               PH_KCL: begin
                  tmp_in = {prod_ff[41:0], 16'd0};
                  mul_a  = rtd_pkg::MUL_A_W'(w_ff[36:12]);
                  mul_b  = rtd_pkg::MUL_B_W'(rtd_pkg::KC_LO);
               end
               PH_PSUM: begin
                  tmp_in = tmp_ff + prod_ff;
               end
               PH_PH: begin
                  mul_a = rtd_pkg::MUL_A_W'(u_ff[36:12]);
                  mul_b = rtd_pkg::MUL_B_W'(tmp_ff[57:39]);
               end
               PH_PL: begin
                  acc_term = rtd_pkg::ACC_W'({prod_ff[43:0], 7'd0});
                  acc_sub  = 1'b1;
                  mul_a    = rtd_pkg::MUL_A_W'(u_ff[36:12]);
                  mul_b    = rtd_pkg::MUL_B_W'(tmp_ff[38:20]);
               end
               PH_PEND: begin
                  acc_term = rtd_pkg::ACC_W'(prod_ff[43:12]);
                  acc_sub  = 1'b1;
               end
               PH_CMP: begin
                  if (acc_ff > target_scaled) begin
                     t_sum = {{2{t_ff[rtd_pkg::TEMP_W-1]}}, t_ff} - signed'({3'd0, step_ff});
                  end else if (acc_ff < target_scaled) begin
                     t_sum = {{2{t_ff[rtd_pkg::TEMP_W-1]}}, t_ff} + signed'({3'd0, step_ff});
                  end
                  if (t_sum < T_LO) begin
                     t_in = T_LO[rtd_pkg::TEMP_W-1:0];
                  end else if (t_sum > T_HI) begin
                     t_in = T_HI[rtd_pkg::TEMP_W-1:0];
                  end else begin
                     t_in = t_sum[rtd_pkg::TEMP_W-1:0];
                  end
                  step_in   = step_ff >> 1;
                  rounds_in = rounds_ff - 1'b1;
                  phase_in  = PH_UU;
                  if (rounds_ff == CNT_W'(1)) begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  phase_in = PH_UU;
               end
            endcase
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_tag_in   = chan_ff;
               rsp_res_in   = target_ff[30:11];
               rsp_temp_in  = t_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (acc_load) begin
         acc_in = signed'(rtd_pkg::ACC_W'(rtd_pkg::R0_SCALED));
      end else if (acc_sub) begin
         acc_in = acc_ff - signed'(acc_term);
      end else begin
         acc_in = acc_ff + signed'(acc_term);
      end
   end

   // Control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         phase_ff             <= PH_UU;
         rounds_ff            <= '0;
         rsp_valid_ff         <= 1'b0;
         ref_resistance_ff    <= rtd_pkg::REF_RESISTANCE_RST;
         start_temperature_ff <= rtd_pkg::START_TEMPERATURE_RST;
         start_step_ff        <= rtd_pkg::START_STEP_RST;
         iteration_count_ff   <= rtd_pkg::ITERATION_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rounds_ff    <= rounds_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               rtd_pkg::REG_REF_RESISTANCE: begin
                  ref_resistance_ff <= csr_wdata[rtd_pkg::REF_W-1:0];
               end
               rtd_pkg::REG_START_TEMPERATURE: begin
                  start_temperature_ff <= signed'(csr_wdata[rtd_pkg::TEMP_W-1:0]);
               end
               rtd_pkg::REG_START_STEP: begin
                  start_step_ff <= csr_wdata[rtd_pkg::STEP_W-1:0];
               end
               rtd_pkg::REG_ITERATION_COUNT: begin
                  iteration_count_ff <= csr_wdata[rtd_pkg::ITER_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      code_ff     <= code_in;
      target_ff   <= target_in;
      t_ff        <= t_in;
      step_ff     <= step_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      tmp_ff      <= tmp_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_tag = rsp_tag_ff;
   assign rsp_resistance  = rsp_res_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign csr_ready       = 1'b1;

endmodule

// ===== verif/tb_rtd_resistance_to_temperature.sv =====
// ----------------------------------------------------------------------------
// Testbench for the PT100 resistance-to-temperature converter
// Runs a short table of directed conversions and register writes, then
// phases of random register settings and converter words. An internal
// fixed-point model of the bisection solver predicts every reading that the
// table does not give, and each returned transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_rtd_resistance_to_temperature;

   localparam int      NUM_PHASES      = 12;
   localparam int      ITEMS_PER_PHASE = 154;
   localparam int      SETTLE_CYCLES   = 4;
   localparam int      DRAIN_CYCLES    = 400;
   localparam int      HOLD_AFTER      = 300;
   localparam int      HOLD_CYCLES     = 3000;
   localparam int      MAX_ROUNDS      = rtd_pkg::MAX_ITERATIONS_DEFAULT;
   localparam longint  TIMEOUT         = 40_000_000;

   // Curve coefficients, resistance in units of 2^-40 ohm
   localparam longint          CVD_R0   = 64'd109951162777600;
   localparam longint          CVD_A    = 64'd1678602068;
   localparam longint unsigned CVD_B    = 64'd63496797;
   localparam longint unsigned CVD_C    = 64'd7716291493;
   localparam longint          TEMP_MIN = -262144;
   localparam longint          TEMP_MAX = 262143;

   typedef struct packed {
      logic                       chan;
      logic [rtd_pkg::RES_W-1:0]  res;
      logic [rtd_pkg::TEMP_W-1:0] temp;
   } reading_type;

   typedef struct packed {
      logic                            is_write;
      logic [rtd_pkg::CSR_INDEX_W-1:0] index;
      logic [rtd_pkg::CSR_DATA_W-1:0]  wdata;
      logic                            chan;
      logic [rtd_pkg::RTD_WORD_W-1:0]  word;
      logic                            typed;
      logic [rtd_pkg::RES_W-1:0]       res;
      logic [rtd_pkg::TEMP_W-1:0]      temp;
   } plan_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_channel_select;
   logic [rtd_pkg::RTD_WORD_W-1:0]      req_rtd_word;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_channel_tag;
   logic [rtd_pkg::RES_W-1:0]           rsp_resistance;
   logic signed [rtd_pkg::TEMP_W-1:0]   rsp_temperature;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [rtd_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [rtd_pkg::CSR_DATA_W-1:0]      csr_wdata;

   // Register mirror
   logic [rtd_pkg::REF_W-1:0]           cfg_ref_res;
   logic signed [rtd_pkg::TEMP_W-1:0]   cfg_start_temp;
   logic [rtd_pkg::STEP_W-1:0]          cfg_start_step;
   logic [rtd_pkg::ITER_W-1:0]          cfg_rounds;

   reading_type   pending_readings[$];
   plan_row_type  plan[$];
   int            accepted_items;
   int            mismatch_count;
   int            stray_count;
   bit            steady_sender;

   rtd_resistance_to_temperature dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel_select (req_channel_select),
      .req_rtd_word       (req_rtd_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel_tag    (rsp_channel_tag),
      .rsp_resistance     (rsp_resistance),
      .rsp_temperature    (rsp_temperature),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // PT100 curve at t (1/256 C), in units of 2^-40 ohm
   function automatic longint cvd_resistance_at(input longint t);
      longint unsigned m, u, w, p;
      longint          r;
      m = (t < 0) ? -t : t;
      u = m * m;
      r = CVD_R0 + CVD_A * t;
      r = r - longint'((CVD_B * u) >> 16);
      // cubic term only below 0 C
      if (t < 0) begin
         w = (m + 64'd25600) * m;
         p = ((w >> 12) * CVD_C) >> 20;
         r = r - longint'((p * (u >> 12)) >> 12);
      end
      return r;
   endfunction

   function automatic logic [rtd_pkg::TEMP_W-1:0] solve_temperature(
         input logic [rtd_pkg::CODE_W-1:0] code);
      longint          target, t, r;
      longint unsigned step_q;
      int              rounds;
      target = (longint'(code) * longint'(cfg_ref_res)) << 21;
      t      = longint'(cfg_start_temp);
      step_q = longint'(cfg_start_step);
      rounds = (cfg_rounds > MAX_ROUNDS) ? MAX_ROUNDS : int'(cfg_rounds);
      for (int i = 0; i < rounds; i++) begin
         r = cvd_resistance_at(t);
         if (r > target) t = t - longint'(step_q);
         else if (r < target) t = t + longint'(step_q);
         if (t < TEMP_MIN) t = TEMP_MIN;
         if (t > TEMP_MAX) t = TEMP_MAX;
         step_q = step_q >> 1;
      end
      return t[rtd_pkg::TEMP_W-1:0];
   endfunction

   function automatic reading_type predict_reading(input logic ch,
                                                   input logic [rtd_pkg::RTD_WORD_W-1:0] word);
      reading_type                rd;
      logic [rtd_pkg::CODE_W-1:0] code;
      longint                     prod;
      code    = word[rtd_pkg::RTD_WORD_W-1:1];
      prod    = longint'(code) * longint'(cfg_ref_res);
      rd.chan = ch;
      rd.res  = prod[rtd_pkg::RES_W+10:11];
      rd.temp = solve_temperature(code);
      return rd;
   endfunction

   function automatic plan_row_type op_write(input logic [rtd_pkg::CSR_INDEX_W-1:0] idx,
                                             input logic [rtd_pkg::CSR_DATA_W-1:0] data);
      plan_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.wdata    = data;
      return row;
   endfunction

   function automatic plan_row_type op_item(input logic ch,
                                            input logic [rtd_pkg::RTD_WORD_W-1:0] word);
      plan_row_type row;
      row      = '0;
      row.chan = ch;
      row.word = word;
      return row;
   endfunction

   function automatic plan_row_type op_checked(input logic ch,
                                               input logic [rtd_pkg::RTD_WORD_W-1:0] word,
                                               input logic [rtd_pkg::RES_W-1:0] res,
                                               input logic [rtd_pkg::TEMP_W-1:0] temp);
      plan_row_type row;
      row       = op_item(ch, word);
      row.typed = 1'b1;
      row.res   = res;
      row.temp  = temp;
      return row;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Register values, with junk above the register width where there is room
   function automatic logic [rtd_pkg::CSR_DATA_W-1:0] pick_ref();
      logic [rtd_pkg::CSR_DATA_W-1:0] v;
      v = rtd_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 9))
         0: v[rtd_pkg::REF_W-1:0] = '0;
         1: v[rtd_pkg::REF_W-1:0] = 16'd1;
         2: v[rtd_pkg::REF_W-1:0] = 16'hFFFF;
         3, 4, 5: v[rtd_pkg::REF_W-1:0] = rtd_pkg::REF_RESISTANCE_RST;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [rtd_pkg::CSR_DATA_W-1:0] pick_start_temp();
      case ($urandom_range(0, 9))
         0: return 19'h40000;
         1: return 19'h3FFFF;
         2: return '0;
         3, 4, 5: return rtd_pkg::START_TEMPERATURE_RST;
         default: return rtd_pkg::CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [rtd_pkg::CSR_DATA_W-1:0] pick_start_step();
      logic [rtd_pkg::CSR_DATA_W-1:0] v;
      v = rtd_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 9))
         0: v[rtd_pkg::STEP_W-1:0] = '0;
         1: v[rtd_pkg::STEP_W-1:0] = 18'd1;
         2: v[rtd_pkg::STEP_W-1:0] = 18'h3FFFF;
         3, 4, 5: v[rtd_pkg::STEP_W-1:0] = rtd_pkg::START_STEP_RST;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [rtd_pkg::CSR_DATA_W-1:0] pick_rounds();
      logic [rtd_pkg::CSR_DATA_W-1:0] v;
      v = rtd_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 11))
         0: v[rtd_pkg::ITER_W-1:0] = '0;
         1: v[rtd_pkg::ITER_W-1:0] = 6'd1;
         2: v[rtd_pkg::ITER_W-1:0] = 6'd32;
         3: v[rtd_pkg::ITER_W-1:0] = 6'd33;
         4: v[rtd_pkg::ITER_W-1:0] = 6'd63;
         5, 6, 7: v[rtd_pkg::ITER_W-1:0] = rtd_pkg::ITERATION_COUNT_RST;
         default: v[rtd_pkg::ITER_W-1:0] = rtd_pkg::ITER_W'($urandom_range(0, 63));
      endcase
      return v;
   endfunction

   // Mostly words within the PT100 range, the rest anywhere
   function automatic logic [rtd_pkg::RTD_WORD_W-1:0] pick_word();
      logic [rtd_pkg::CODE_W-1:0] code;
      if ($urandom_range(0, 9) < 7) begin
         code = rtd_pkg::CODE_W'($urandom_range(1300, 30500));
         return {code, 1'($urandom)};
      end
      return rtd_pkg::RTD_WORD_W'($urandom);
   endfunction

   task automatic write_csr(input logic [rtd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rtd_pkg::CSR_DATA_W-1:0] data, input bit hold_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (!hold_valid) csr_valid <= 1'b0;
      case (idx)
         rtd_pkg::REG_REF_RESISTANCE:    cfg_ref_res    = data[rtd_pkg::REF_W-1:0];
         rtd_pkg::REG_START_TEMPERATURE: cfg_start_temp = data[rtd_pkg::TEMP_W-1:0];
         rtd_pkg::REG_START_STEP:        cfg_start_step = data[rtd_pkg::STEP_W-1:0];
         rtd_pkg::REG_ITERATION_COUNT:   cfg_rounds     = data[rtd_pkg::ITER_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one conversion and record its expected reading once accepted
   task automatic send_reading(input logic ch, input logic [rtd_pkg::RTD_WORD_W-1:0] word,
                               input logic typed, input logic [rtd_pkg::RES_W-1:0] res,
                               input logic [rtd_pkg::TEMP_W-1:0] temp);
      int          gap;
      reading_type rd;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_channel_select <= ch;
      req_rtd_word       <= word;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         rd.chan = ch;
         rd.res  = res;
         rd.temp = temp;
      end else begin
         rd = predict_reading(ch, word);
      end
      pending_readings.push_back(rd);
      accepted_items++;
   endtask

   // Drop valid and wait for every outstanding reading before a register write
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_channel_select = 1'b0;
      req_rtd_word       = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      cfg_ref_res        = rtd_pkg::REF_RESISTANCE_RST;
      cfg_start_temp     = rtd_pkg::START_TEMPERATURE_RST;
      cfg_start_step     = rtd_pkg::START_STEP_RST;
      cfg_rounds         = rtd_pkg::ITERATION_COUNT_RST;
      accepted_items     = 0;
      steady_sender      = 1'b0;

      // Reset defaults: extremes, near 0 C, below 0 C, well above 0 C
      plan.push_back(op_item(1'b0, 16'h0000));
      plan.push_back(op_item(1'b1, 16'hFFFF));
      plan.push_back(op_item(1'b0, 16'h3B88));
      plan.push_back(op_item(1'b1, 16'h2FA0));
      plan.push_back(op_item(1'b0, 16'h5276));
      plan.push_back(op_item(1'b1, 16'h0001));
      plan.push_back(op_item(1'b0, 16'h5555));
      plan.push_back(op_item(1'b1, 16'hAAAA));
      // No rounds: temperature is the start value
      plan.push_back(op_write(rtd_pkg::REG_ITERATION_COUNT, 19'd0));
      plan.push_back(op_write(rtd_pkg::REG_START_TEMPERATURE, 19'h40000));
      plan.push_back(op_checked(1'b0, 16'h0000, 20'd0, -19'sd262144));
      plan.push_back(op_checked(1'b1, 16'hFFFF, 20'd110076, -19'sd262144));
      plan.push_back(op_write(rtd_pkg::REG_REF_RESISTANCE, 19'd65535));
      plan.push_back(op_checked(1'b1, 16'hFFFF, 20'd1048528, -19'sd262144));
      plan.push_back(op_write(rtd_pkg::REG_START_TEMPERATURE, 19'h3FFFF));
      plan.push_back(op_checked(1'b0, 16'h0002, 20'd31, 19'sd262143));
      // fault bit ignored
      plan.push_back(op_checked(1'b1, 16'h0003, 20'd31, 19'sd262143));
      // Zero reference, zero step, rounds beyond the limit
      plan.push_back(op_write(rtd_pkg::REG_REF_RESISTANCE, 19'd0));
      plan.push_back(op_write(rtd_pkg::REG_START_STEP, 19'd0));
      plan.push_back(op_write(rtd_pkg::REG_ITERATION_COUNT, 19'd63));
      plan.push_back(op_checked(1'b0, 16'hFFFF, 20'd0, 19'sd262143));
      plan.push_back(op_write(rtd_pkg::REG_START_STEP, 19'h3FFFF));
      plan.push_back(op_write(rtd_pkg::REG_ITERATION_COUNT, 19'd33));
      plan.push_back(op_item(1'b1, 16'hFFFF));
      plan.push_back(op_write(rtd_pkg::REG_START_TEMPERATURE, 19'h40000));
      plan.push_back(op_write(rtd_pkg::REG_REF_RESISTANCE, 19'd1));
      plan.push_back(op_item(1'b0, 16'hFFFF));
      plan.push_back(op_item(1'b1, 16'h8000));
      plan.push_back(op_write(rtd_pkg::REG_ITERATION_COUNT, 19'd32));
      plan.push_back(op_write(rtd_pkg::REG_START_STEP, 19'd1));
      plan.push_back(op_item(1'b0, 16'h7FFE));
      // Back to defaults, with junk above each register width where there is room
      plan.push_back(op_write(rtd_pkg::REG_REF_RESISTANCE, 19'h71AE0));
      plan.push_back(op_write(rtd_pkg::REG_START_TEMPERATURE, 19'd83200));
      plan.push_back(op_write(rtd_pkg::REG_START_STEP, 19'h50680));
      plan.push_back(op_write(rtd_pkg::REG_ITERATION_COUNT, 19'h7FFD4));
      plan.push_back(op_item(1'b0, 16'h3B88));
      plan.push_back(op_item(1'b1, 16'hC350));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < plan.size(); i++) begin
         if (plan[i].is_write) begin
            if (i == 0 || !plan[i-1].is_write) settle();
            write_csr(plan[i].index, plan[i].wdata,
                      (i + 1 < plan.size()) && plan[i+1].is_write);
         end else begin
            send_reading(plan[i].chan, plan[i].word, plan[i].typed, plan[i].res, plan[i].temp);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         write_csr(rtd_pkg::REG_REF_RESISTANCE, pick_ref(), 1'b1);
         write_csr(rtd_pkg::REG_START_TEMPERATURE, pick_start_temp(), 1'b1);
         write_csr(rtd_pkg::REG_START_STEP, pick_start_step(), 1'b1);
         write_csr(rtd_pkg::REG_ITERATION_COUNT, pick_rounds(), 1'b0);
         steady_sender = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_reading(1'($urandom), pick_word(), 1'b0, '0, '0);
      end
      req_valid <= 1'b0;

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && stray_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver back-pressure: random stalls, long free runs, one long hold-off
   initial begin : rsp_pacing
      bit hold_done;
      int stall_len;
      int run_len;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && accepted_items >= HOLD_AFTER) begin
            // hold off long enough for the block to back up into its input
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall_len = pick_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600)
                                                 : $urandom_range(1, 8);
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            stray_count++;
            if (stray_count + mismatch_count <= 10)
               $display("%0t: unexpected reading ch=%0d res=%0d temp=%0d", $realtime,
                        rsp_channel_tag, rsp_resistance, rsp_temperature);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_channel_tag !== want.chan || rsp_resistance !== want.res ||
                rsp_temperature !== want.temp) begin
               mismatch_count++;
               if (stray_count + mismatch_count <= 10)
                  $display("%0t: reading mismatch ch %0d/%0d res %0d/%0d temp %0d/%0d (exp/act)",
                           $realtime, want.chan, rsp_channel_tag, want.res, rsp_resistance,
                           $signed(want.temp), rsp_temperature);
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT);
      $display("TEST FAILED");
      $finish;
   end

endmodule
